FILE: hdl/trb_pkg.sv
// shared types and constants of the timestamp reorder buffer
// no dependencies; imported by every module of the block
package trb_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned HOLD_W   = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W    = (CNT_W > HOLD_W) ? CNT_W : HOLD_W;

  // input event codes
  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PACKET = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END    = 2'd2;

  // result kinds
  localparam logic [MODE_W-1:0] KIND_START  = 2'd0;
  localparam logic [MODE_W-1:0] KIND_PACKET = 2'd1;
  localparam logic [MODE_W-1:0] KIND_END    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SORT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_COUNT  = 1'd1;

  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {
    OP_KEEP,
    OP_INSERT,
    OP_SWAP,
    OP_SHIFT
  } cell_op_e;

  typedef struct packed {
    logic [TIME_W-1:0]   arrival_time;
    logic [HANDLE_W-1:0] packet_handle;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   item;
  } cell_cmd_t;

endpackage

FILE: hdl/trb_cell.sv
// one cell of the sorted chain: holds a single entry
// depends on trb_pkg; swaps data with its left and right neighbours
module trb_cell import trb_pkg::*; (
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      valid_i,
  input  entry_t    left_i,
  input  logic      left_ins_i,
  input  entry_t    right_i,
  input  logic      right_ins_i,
  output entry_t    entry_o,
  output logic      ins_o
);

  entry_t entry_q, entry_d;

  // empty cells count as later than any new beat
  assign ins_o   = !valid_i || (entry_q.arrival_time > cmd_i.item.arrival_time);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (ins_o) begin
          entry_d = left_ins_i ? left_i : cmd_i.item;
        end
      end
      OP_SWAP: begin
        // head leaves, everything before the slot moves one place left
        if (!right_ins_i) begin
          entry_d = right_i;
        end else if (!ins_o) begin
          entry_d = cmd_i.item;
        end
      end
      OP_SHIFT: entry_d = right_i;
      default:  entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: hdl/trb_chain.sv
// row of sorted cells, earliest timestamp at the head
// depends on trb_pkg and trb_cell
module trb_chain import trb_pkg::*; (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [CNT_W-1:0] count_i,
  output entry_t           head_o,
  output logic             head_ins_o
);

  entry_t entries [DEPTH];
  logic   ins     [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_w, right_w;
    logic   left_ins_w, right_ins_w;

    if (i == 0) begin : g_first
      assign left_w     = '0;
      assign left_ins_w = 1'b0;
    end else begin : g_mid_l
      assign left_w     = entries[i-1];
      assign left_ins_w = ins[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w     = '0;
      assign right_ins_w = 1'b1;
    end else begin : g_mid_r
      assign right_w     = entries[i+1];
      assign right_ins_w = ins[i+1];
    end

    trb_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd_i),
      .valid_i    (count_i > CNT_W'(i)),
      .left_i     (left_w),
      .left_ins_i (left_ins_w),
      .right_i    (right_w),
      .right_ins_i(right_ins_w),
      .entry_o    (entries[i]),
      .ins_o      (ins[i])
    );
  end

  assign head_o     = entries[0];
  assign head_ins_o = ins[0];

endmodule

FILE: hdl/timestamp_reorder_buffer_top.sv
// top level of the timestamp reorder buffer: control, config and result register
// depends on trb_pkg and trb_chain
//
// Packets are kept in a chain of DEPTH cells sorted by arrival time; every cell
// compares its own timestamp with the incoming one in parallel and moves one
// place left or right, so a start or packet beat is taken every cycle while
// the result register is free and no end beat is flushing. Once more than
// hold_count packets are held the earliest leaves, ties in arrival order. An end
// beat flushes the chain one entry per cycle while the result register is free,
// then sends the end marker with last set. No clearing pass is needed after reset.
module timestamp_reorder_buffer_top import trb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [TIME_W-1:0]    arrival_time_i,
  input  logic [HANDLE_W-1:0]  packet_handle_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [MODE_W-1:0]    event_kind_o,
  output logic [TIME_W-1:0]    out_time_o,
  output logic [HANDLE_W-1:0]  out_handle_o,
  output logic                 last_o
);

  state_e state_q, state_d;
  logic   sort_enable_q;
  logic [HOLD_W-1:0] hold_count_q;
  logic [CNT_W-1:0]  count_q, count_d;

  logic                out_valid_q, out_last_q, out_last_d, out_load;
  logic [MODE_W-1:0]   out_kind_q, out_kind_d;
  logic [TIME_W-1:0]   out_time_q, out_time_d;
  logic [HANDLE_W-1:0] out_handle_q, out_handle_d;

  cell_cmd_t cmd;
  entry_t    head;
  logic      head_ins;
  logic      slot_free, in_fire, over;
  logic [CMP_W-1:0] hold_eff;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // hold above the chain length acts as the chain length
  assign hold_eff = (CMP_W'(hold_count_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                          : CMP_W'(hold_count_q);
  assign over     = CMP_W'(count_q) >= hold_eff;

  trb_chain u_chain (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .count_i   (count_q),
    .head_o    (head),
    .head_ins_o(head_ins)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire && mode_i == MODE_END) state_d = ST_FLUSH;
      ST_FLUSH: if (slot_free && count_q == '0) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = OP_KEEP;
    cmd.item     = '{arrival_time: arrival_time_i, packet_handle: packet_handle_i};
    count_d      = count_q;
    out_load     = 1'b0;
    out_kind_d   = KIND_PACKET;
    out_time_d   = arrival_time_i;
    out_handle_d = packet_handle_i;
    out_last_d   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (mode_i)
            MODE_START: begin
              count_d      = '0;
              out_load     = 1'b1;
              out_kind_d   = KIND_START;
              out_time_d   = '0;
              out_handle_d = '0;
            end
            MODE_PACKET: begin
              if (!sort_enable_q) begin
                out_load = 1'b1;
              end else if (over) begin
                out_load = 1'b1;
                // head ties or precedes the new beat: head leaves instead
                if (!head_ins) begin
                  cmd.op       = OP_SWAP;
                  out_time_d   = head.arrival_time;
                  out_handle_d = head.packet_handle;
                end
              end else begin
                cmd.op  = OP_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (count_q != '0) begin
            cmd.op       = OP_SHIFT;
            count_d      = count_q - 1'b1;
            out_time_d   = head.arrival_time;
            out_handle_d = head.packet_handle;
            out_last_d   = 1'b0;
          end else begin
            out_kind_d   = KIND_END;
            out_time_d   = '0;
            out_handle_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      sort_enable_q <= 1'b1;
      hold_count_q  <= HOLD_W'(1);
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SORT_ENABLE: sort_enable_q <= cfg_data_i[0];
          CFG_HOLD_COUNT:  hold_count_q  <= cfg_data_i[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q   <= out_kind_d;
      out_time_q   <= out_time_d;
      out_handle_q <= out_handle_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign out_time_o   = out_time_q;
  assign out_handle_o = out_handle_q;
  assign last_o       = out_last_q;

endmodule

FILE: hdl/trb_checker.sv
// port-level checks of the timestamp reorder buffer, bound to the top level
// depends on trb_pkg and timestamp_reorder_buffer_top
module trb_checker import trb_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [MODE_W-1:0]    mode_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [MODE_W-1:0]    event_kind_o,
  input logic [TIME_W-1:0]    out_time_o,
  input logic [HANDLE_W-1:0]  out_handle_o,
  input logic                 last_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o)
      && $stable(out_time_o) && $stable(out_handle_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  // no new input beat while the result register is blocked
  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result register full");

  // a start beat yields its marker in the next cycle
  a_start_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && mode_i == MODE_START |=>
      out_valid_o && event_kind_o == KIND_START && last_o)
    else $error("start marker missing");

  // markers carry zeros and the end marker closes its event
  a_marker_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_kind_o != KIND_PACKET |->
      out_time_o == '0 && out_handle_o == '0 && last_o)
    else $error("bad marker beat");

endmodule

bind timestamp_reorder_buffer_top trb_checker u_trb_checker (.*);
